[src/sorted_list_with_free_list_assert.svh]
// ----------------------------------------------------------------------------
// sorted_list_with_free_list_assert.svh
// assertion macros for the sorted record store, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_WITH_FREE_LIST_ASSERT_SVH
`define SORTED_LIST_WITH_FREE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLFL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLFL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define SLFL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg)
`define SLFL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

[src/slfl_pkg.sv]
// ----------------------------------------------------------------------------
// slfl_pkg
// operation and status codes of the sorted record store
// ----------------------------------------------------------------------------
package slfl_pkg;

  localparam int OP_BITS        = 2;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_OUT_BITS = 6;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;

endpackage

[src/sorted_list_with_free_list.sv]
// ----------------------------------------------------------------------------
// sorted_list_with_free_list
// sorted record store: circular linked list in ascending key order plus a
// free-node stack, kept in two synchronous node memories
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An insert, delete, lookup or update
// walks the list from the head, one node per cycle, because every step needs
// the link word just read from the node memory (the read is registered).
// A lookup or update visits nodes up to the match (at most the record count);
// a delete adds a state that pushes the freed node on the free stack, and an
// insert adds states that pop the free stack and patch two links through the
// single link write port. An insert into an empty store needs no walk, and a
// full-store insert or an operation on an empty store goes straight to the result.
// Input beats are taken only when the engine is idle; the finished result
// sits in an output register, so a new beat can be taken while the previous
// result waits.
// The link memory needs no clearing after reset: a fill mark counts nodes
// ever handed out, and a never-used node reads as linking to its successor.
// Records with equal keys keep arrival order; delete, lookup and update act
// on the first record with the key.
// ----------------------------------------------------------------------------
module sorted_list_with_free_list
  import slfl_pkg::*;
#(
  parameter int CAPACITY     = 32,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_BITS-1:0]        in_op,
  input  logic [KEY_BITS-1:0]       in_key,
  input  logic [PAYLOAD_BITS-1:0]   in_payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_BITS-1:0]    out_status,
  output logic                      out_found,
  output logic [PAYLOAD_BITS-1:0]   out_payload_out,
  output logic [COUNT_OUT_BITS-1:0] out_count
);

  // node index and record count widths
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } node_data_t;

  // one-hot engine states
  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,  // waiting for a beat
    S_POP       = 7'b0000010,  // free-stack link read is back
    S_INS_WALK  = 7'b0000100,  // looking for the insert point
    S_INS_FIX   = 7'b0001000,  // second link patch of an insert
    S_FIND_WALK = 7'b0010000,  // looking for the first match
    S_DEL_FREE  = 7'b0100000,  // push the deleted node on the free stack
    S_RESULT    = 7'b1000000   // hand the result to the output register
  } state_t;

  // --------------------------------------------------------------------------
  // node memories: key/payload and link, both read at the same address
  // --------------------------------------------------------------------------
  node_data_t        data_mem [CAPACITY];
  logic [IW-1:0]     link_mem [CAPACITY];

  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  node_data_t        data_rd_q;
  logic [IW-1:0]     link_rd_q;

  logic              data_we;
  logic [IW-1:0]     data_waddr;
  node_data_t        data_wdata;
  logic              link_we;
  logic [IW-1:0]     link_waddr;
  logic [IW-1:0]     link_wdata;

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (mem_re) begin
      data_rd_q <= data_mem[mem_raddr];
      link_rd_q <= link_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // engine registers
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           tail_r, tail_nxt;
  logic [IW-1:0]           free_head_r, free_head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;        // nodes ever handed out
  logic                    out_valid_r, out_valid_nxt;

  logic [OP_BITS-1:0]      op_r, op_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [IW-1:0]           prev_r, prev_nxt;
  logic [CW-1:0]           step_r, step_nxt;
  logic [IW-1:0]           new_r, new_nxt;          // node taken for an insert
  logic [IW-1:0]           after_r, after_nxt;
  logic [IW-1:0]           after_link_r, after_link_nxt;
  logic                    have_after_r, have_after_nxt;
  logic [IW-1:0]           fix_r, fix_nxt;          // node whose link gets new_r
  logic [STATUS_BITS-1:0]  res_status_r, res_status_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;
  logic [STATUS_BITS-1:0]  out_status_r, out_status_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic [COUNT_OUT_BITS-1:0] out_count_r, out_count_nxt;

  // helper terms
  logic          in_accept;
  logic          out_free;
  logic          last_step;
  logic          key_le;
  logic          key_eq;
  logic          ins_have;
  logic [IW-1:0] ins_after;
  logic [IW-1:0] ins_after_link;
  logic          new_is_used;

  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign last_step   = (step_r == count_r - CW'(1));
  assign key_le      = (data_rd_q.key <= key_r);
  assign key_eq      = (data_rd_q.key == key_r);
  // insert point: the last node whose key is not above the new key
  assign ins_have       = key_le || have_after_r;
  assign ins_after      = key_le ? cur_r : after_r;
  assign ins_after_link = key_le ? link_rd_q : after_link_r;
  // nodes below the fill mark have a written link word
  assign new_is_used = (CW'(new_r) < fill_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    step_nxt       = step_r;
    new_nxt        = new_r;
    after_nxt      = after_r;
    after_link_nxt = after_link_r;
    have_after_nxt = have_after_r;
    fix_nxt        = fix_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pay_nxt    = res_pay_r;

    mem_re     = 1'b0;
    mem_raddr  = head_r;
    data_we    = 1'b0;
    data_waddr = new_r;
    data_wdata = '{key: key_r, payload: pay_r};
    link_we    = 1'b0;
    link_waddr = new_r;
    link_wdata = new_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt         = in_op;
          key_nxt        = in_key;
          pay_nxt        = in_payload;
          res_found_nxt  = 1'b0;
          res_pay_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_op == OP_INSERT) begin
            if (count_r == FULL_CNT) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RESULT;
            end else begin
              // fetch the link of the free-stack top
              new_nxt   = free_head_r;
              mem_re    = 1'b1;
              mem_raddr = free_head_r;
              state_nxt = S_POP;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESULT;
          end else begin
            cur_nxt   = head_r;
            prev_nxt  = tail_r;
            step_nxt  = '0;
            mem_re    = 1'b1;
            mem_raddr = head_r;
            state_nxt = S_FIND_WALK;
          end
        end
      end

      S_POP: begin
        // pop: never-used nodes chain to the next index, wrapping
        if (new_is_used) begin
          free_head_nxt = link_rd_q;
        end else begin
          free_head_nxt = (new_r == LAST_IDX) ? '0 : new_r + IW'(1);
          fill_nxt      = fill_r + CW'(1);
        end
        if (count_r == '0) begin
          // first record links to itself
          data_we    = 1'b1;
          link_we    = 1'b1;
          link_waddr = new_r;
          link_wdata = new_r;
          head_nxt   = new_r;
          tail_nxt   = new_r;
          count_nxt  = count_r + CW'(1);
          state_nxt  = S_RESULT;
        end else begin
          cur_nxt        = head_r;
          step_nxt       = '0;
          have_after_nxt = 1'b0;
          mem_re         = 1'b1;
          mem_raddr      = head_r;
          state_nxt      = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        if (key_le) begin
          after_nxt      = cur_r;
          after_link_nxt = link_rd_q;
          have_after_nxt = 1'b1;
        end
        if (key_le && !last_step) begin
          cur_nxt   = link_rd_q;
          step_nxt  = step_r + CW'(1);
          mem_re    = 1'b1;
          mem_raddr = link_rd_q;
        end else begin
          // write the new node, patch the other link next cycle
          data_we    = 1'b1;
          link_we    = 1'b1;
          link_waddr = new_r;
          if (ins_have) begin
            link_wdata = ins_after_link;
            fix_nxt    = ins_after;
            if (ins_after == tail_r) begin
              tail_nxt = new_r;
            end
          end else begin
            // smaller than every key: new head, old tail wraps to it
            link_wdata = head_r;
            fix_nxt    = tail_r;
            head_nxt   = new_r;
          end
          state_nxt = S_INS_FIX;
        end
      end

      S_INS_FIX: begin
        link_we    = 1'b1;
        link_waddr = fix_r;
        link_wdata = new_r;
        count_nxt  = count_r + CW'(1);
        state_nxt  = S_RESULT;
      end

      S_FIND_WALK: begin
        if (key_eq) begin
          res_found_nxt = 1'b1;
          unique case (op_r)
            OP_LOOKUP: begin
              res_pay_nxt = data_rd_q.payload;
              state_nxt   = S_RESULT;
            end
            OP_UPDATE: begin
              data_we    = 1'b1;
              data_waddr = cur_r;
              data_wdata = '{key: data_rd_q.key, payload: pay_r};
              state_nxt  = S_RESULT;
            end
            default: begin
              // delete: unlink from the predecessor unless it is the only one
              if (count_r != CW'(1)) begin
                link_we    = 1'b1;
                link_waddr = prev_r;
                link_wdata = link_rd_q;
                if (cur_r == head_r) begin
                  head_nxt = link_rd_q;
                end
                if (cur_r == tail_r) begin
                  tail_nxt = prev_r;
                end
              end
              state_nxt = S_DEL_FREE;
            end
          endcase
        end else if (last_step) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rd_q;
          step_nxt  = step_r + CW'(1);
          mem_re    = 1'b1;
          mem_raddr = link_rd_q;
        end
      end

      S_DEL_FREE: begin
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - CW'(1);
        state_nxt     = S_RESULT;
      end

      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: loaded when the result is ready and the slot frees up
  logic out_load;
  assign out_load = (state_r == S_RESULT) && out_free;

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_pay_nxt    = out_pay_r;
    out_count_nxt  = out_count_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_found_nxt  = res_found_r;
      out_pay_nxt    = res_pay_r;
      out_count_nxt  = COUNT_OUT_BITS'(count_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    step_r       <= step_nxt;
    new_r        <= new_nxt;
    after_r      <= after_nxt;
    after_link_r <= after_link_nxt;
    have_after_r <= have_after_nxt;
    fix_r        <= fix_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_payload_out = out_pay_r;
  assign out_count       = out_count_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "sorted_list_with_free_list_assert.svh"

  `SLFL_ASSERT_NOW(a_no_rw_overlap, clk, rst_n, mem_re, !(data_we || link_we), "rd/wr clash")
  `SLFL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT, "count over capacity")
  `SLFL_ASSERT_NOW(a_fill_covers_count, clk, rst_n, 1'b1, fill_r >= count_r, "fill below count")
  `SLFL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, state_r != S_IDLE, "not busy")

endmodule

[tb/sorted_list_checker.sv]
// ----------------------------------------------------------------------------
// sorted_list_checker
// watches both channels of the sorted record store, keeps its own copy of the
// node array and free stack, and compares every result beat in order
// ----------------------------------------------------------------------------
module sorted_list_checker
  import slfl_pkg::*;
#(
  parameter int CAPACITY     = 32,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OP_BITS-1:0]        in_op,
  input  logic [KEY_BITS-1:0]       in_key,
  input  logic [PAYLOAD_BITS-1:0]   in_payload,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [STATUS_BITS-1:0]    out_status,
  input  logic                      out_found,
  input  logic [PAYLOAD_BITS-1:0]   out_payload_out,
  input  logic [COUNT_OUT_BITS-1:0] out_count,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_BITS = $clog2(CAPACITY);

  typedef logic [IDX_BITS-1:0] node_idx_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]    status;
    logic                      found;
    logic [PAYLOAD_BITS-1:0]   payload_out;
    logic [COUNT_OUT_BITS-1:0] count;
  } store_result_t;

  logic [KEY_BITS-1:0]     rec_key  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] rec_pay  [CAPACITY];
  node_idx_t               rec_link [CAPACITY];
  node_idx_t               head_node;
  node_idx_t               tail_node;
  node_idx_t               free_top;
  int unsigned             n_records;

  store_result_t awaited_results[$];
  store_result_t got_result;
  store_result_t want_result;
  int            fail_count = 0;

  initial mismatches = 0;
  initial pending = 0;

  function automatic void clear_store();
    for (int i = 0; i < CAPACITY; i++) begin
      rec_link[i] = node_idx_t'((i + 1) % CAPACITY);
    end
    head_node = '0;
    tail_node = '0;
    free_top  = '0;
    n_records = 0;
  endfunction

  // first record with the key, plus its predecessor on the ring
  function automatic bit find_first(input logic [KEY_BITS-1:0] key,
                                    output node_idx_t node, output node_idx_t prev);
    node_idx_t i;
    node_idx_t p;
    bit        hit;
    i    = head_node;
    p    = tail_node;
    hit  = 1'b0;
    node = '0;
    prev = '0;
    for (int k = 0; k < n_records && !hit; k++) begin
      if (rec_key[i] == key) begin
        node = i;
        prev = p;
        hit  = 1'b1;
      end else begin
        p = i;
        i = rec_link[i];
      end
    end
    return hit;
  endfunction

  function automatic logic [STATUS_BITS-1:0] insert_record(input logic [KEY_BITS-1:0] key,
                                                           input logic [PAYLOAD_BITS-1:0] pay);
    node_idx_t n;
    node_idx_t cur;
    node_idx_t after;
    bit        have_after;
    bit        stop;
    if (n_records >= CAPACITY) return ST_FULL;
    n          = free_top;
    free_top   = rec_link[n];
    rec_key[n] = key;
    rec_pay[n] = pay;
    if (n_records == 0) begin
      rec_link[n] = n;
      head_node   = n;
      tail_node   = n;
    end else begin
      cur        = head_node;
      after      = cur;
      have_after = 1'b0;
      stop       = 1'b0;
      // equal keys are passed, so the new record lands behind them
      for (int k = 0; k < n_records && !stop; k++) begin
        if (rec_key[cur] <= key) begin
          after      = cur;
          have_after = 1'b1;
          cur        = rec_link[cur];
        end else begin
          stop = 1'b1;
        end
      end
      if (!have_after) begin
        rec_link[n]         = head_node;
        rec_link[tail_node] = n;
        head_node           = n;
      end else begin
        rec_link[n]     = rec_link[after];
        rec_link[after] = n;
        if (after == tail_node) tail_node = n;
      end
    end
    n_records++;
    return ST_OK;
  endfunction

  function automatic store_result_t predict_result(input logic [OP_BITS-1:0] op,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [PAYLOAD_BITS-1:0] pay);
    store_result_t r;
    node_idx_t     node;
    node_idx_t     prev;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      r.status = insert_record(key, pay);
    end else if (!find_first(key, node, prev)) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.found = 1'b1;
      case (op)
        OP_DELETE: begin
          if (n_records > 1) begin
            rec_link[prev] = rec_link[node];
            if (node == head_node) head_node = rec_link[node];
            if (node == tail_node) tail_node = prev;
          end
          rec_link[node] = free_top;
          free_top       = node;
          n_records--;
        end
        OP_LOOKUP: r.payload_out = rec_pay[node];
        default:   rec_pay[node] = pay;
      endcase
    end
    r.count = n_records[COUNT_OUT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_store();
      awaited_results.delete();
    end else begin
      // result side first: an input taken at this edge cannot be answered yet
      if (out_valid && !out_stall) begin
        got_result = '{out_status, out_found, out_payload_out, out_count};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing awaited: status %0d found %0d payload %h count %0d",
                     $realtime, out_status, out_found, out_payload_out, out_count);
        end else begin
          want_result = awaited_results.pop_front();
          if (got_result !== want_result) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected status %0d found %0d payload %h count %0d, got status %0d found %0d payload %h count %0d",
                       $realtime, want_result.status, want_result.found,
                       want_result.payload_out, want_result.count,
                       got_result.status, got_result.found,
                       got_result.payload_out, got_result.count);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(predict_result(in_op, in_key, in_payload));
    end
    pending    <= awaited_results.size();
    mismatches <= fail_count;
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// stimulus for the sorted record store: a directed run through the empty,
// head, tail, equal-key and last-record cases, then random segments that
// fill, flood, drain and mix the store under three idling profiles
// ----------------------------------------------------------------------------
module testbench
  import slfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY      = 32;
  localparam int KEY_BITS      = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int SEGMENTS      = 29;
  localparam int SEG_ITEMS     = 50;
  localparam int SEGS_PER_PASS = 10;
  localparam int POOL_SPAN     = 24;
  localparam int TAIL_CYCLES   = 40;
  localparam int STUCK_LIMIT   = 4000;

  // random segment flavors
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_FLOOD} seg_mode_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [OP_BITS-1:0]        in_op      = OP_LOOKUP;
  logic [KEY_BITS-1:0]       in_key     = '0;
  logic [PAYLOAD_BITS-1:0]   in_payload = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [STATUS_BITS-1:0]    out_status;
  logic                      out_found;
  logic [PAYLOAD_BITS-1:0]   out_payload_out;
  logic [COUNT_OUT_BITS-1:0] out_count;

  int mismatches;
  int pending;
  int send_gap_pct  = 6;   // chance of a sender gap cycle before each beat
  int recv_stall_pct = 52; // chance of out_stall in any cycle
  int stuck_cycles  = 0;

  logic [KEY_BITS-1:0] pool_base = '0;
  seg_mode_t           seg_mode;

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  sorted_list_with_free_list #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_payload_out(out_payload_out),
    .out_count      (out_count)
  );

  sorted_list_checker #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_payload_out(out_payload_out),
    .out_count      (out_count),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // receiver back-pressure, one fresh draw per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: too long without a beat on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one input beat, with random gap cycles ahead of it
  task automatic send_op(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                         input logic [PAYLOAD_BITS-1:0] pay);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_key     <= key;
    in_payload <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender holds off until every awaited result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly keys from a narrow pool so that hits and equal keys are common
  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(3) == 0) return KEY_BITS'($urandom);
    return pool_base + KEY_BITS'($urandom_range(POOL_SPAN - 1));
  endfunction

  function automatic logic [OP_BITS-1:0] pick_op(input seg_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 70) return OP_INSERT;
        if (r < 80) return OP_DELETE;
        if (r < 90) return OP_LOOKUP;
        return OP_UPDATE;
      end
      MODE_DRAIN: begin
        if (r < 15) return OP_INSERT;
        if (r < 75) return OP_DELETE;
        if (r < 88) return OP_LOOKUP;
        return OP_UPDATE;
      end
      MODE_FLOOD: begin
        if (r < 90) return OP_INSERT;
        return OP_LOOKUP;
      end
      default: return OP_BITS'($urandom_range(3));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: every search misses
    send_op(OP_LOOKUP, 16'h0000, 32'h0000_0000);
    send_op(OP_DELETE, 16'hffff, 32'hffff_ffff);
    send_op(OP_UPDATE, 16'h8000, 32'h1234_5678);
    // first insert links to itself, then a new head, a new tail, an equal key
    send_op(OP_INSERT, 16'h8000, 32'h0000_0000);
    send_op(OP_INSERT, 16'h0000, 32'hffff_ffff);
    send_op(OP_INSERT, 16'hffff, 32'haaaa_aaaa);
    send_op(OP_INSERT, 16'h8000, 32'h5555_5555);
    // first of the equal keys is the one found
    send_op(OP_LOOKUP, 16'h8000, 32'hffff_ffff);
    send_op(OP_UPDATE, 16'h8000, 32'h1234_5678);
    send_op(OP_LOOKUP, 16'h8000, 32'h0000_0000);
    send_op(OP_LOOKUP, 16'hffff, 32'h0000_0000);
    // drop head and tail, then the last two records
    send_op(OP_DELETE, 16'h0000, 32'h0000_0000);
    send_op(OP_DELETE, 16'hffff, 32'h0000_0000);
    send_op(OP_LOOKUP, 16'h1234, 32'h0000_0000);
    send_op(OP_DELETE, 16'h8000, 32'h0000_0000);
    send_op(OP_LOOKUP, 16'h8000, 32'h0000_0000);
    send_op(OP_DELETE, 16'h8000, 32'h0000_0000);
    send_op(OP_LOOKUP, 16'h8000, 32'h0000_0000);
    // freed node comes back first
    send_op(OP_INSERT, 16'h0001, 32'hdead_beef);
    send_op(OP_LOOKUP, 16'h0001, 32'h0000_0000);
    send_op(OP_DELETE, 16'h0001, 32'h0000_0000);
    wait_idle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // idling profile changes between passes, each with the pipe empty
      if (seg == SEGS_PER_PASS) begin
        wait_idle();
        send_gap_pct   = 52;
        recv_stall_pct = 6;
      end else if (seg == 2 * SEGS_PER_PASS) begin
        wait_idle();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (seg % 5 == 0) pool_base = KEY_BITS'($urandom_range(65535 - POOL_SPAN));
      seg_mode = seg_mode_t'($urandom_range(3));
      for (int j = 0; j < SEG_ITEMS; j++) begin
        send_op(pick_op(seg_mode), pick_key(), PAYLOAD_BITS'($urandom));
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sorted_list_with_free_list.f]
+incdir+src
src/slfl_pkg.sv
src/sorted_list_with_free_list.sv
tb/sorted_list_checker.sv
tb/testbench.sv
